// ===== rtl/ccw_pkg.sv =====
// Shared types, constants and helper functions of the calendar clock.
`default_nettype none

package ccw_pkg;

  // Field widths
  localparam int YEAR_W = 16;
  localparam int BYTE_W = 8;
  localparam int WDAY_W = 3;
  localparam int CMD_W  = 2;
  localparam int CNT_W  = 16;

  // Command codes carried in an input beat
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // Calendar limits
  localparam logic [BYTE_W-1:0] SEC_LIMIT  = 8'd60;
  localparam logic [BYTE_W-1:0] MIN_LIMIT  = 8'd60;
  localparam logic [BYTE_W-1:0] HOUR_LIMIT = 8'd24;
  localparam logic [BYTE_W-1:0] MONTHS     = 8'd12;
  localparam logic [BYTE_W-1:0] DAY_MAX    = 8'd31;
  localparam logic [YEAR_W-1:0] YEAR_MIN   = 16'd2015;
  localparam logic [YEAR_W-1:0] YEAR_MAX   = 16'd2050;
  localparam logic [WDAY_W-1:0] SUNDAY     = 3'd7;

  // Reset time: 2019-01-01 08:00:00, Tuesday
  localparam logic [YEAR_W-1:0] RST_YEAR  = 16'd2019;
  localparam logic [BYTE_W-1:0] RST_MONTH = 8'd1;
  localparam logic [BYTE_W-1:0] RST_DAY   = 8'd1;
  localparam logic [BYTE_W-1:0] RST_HOUR  = 8'd8;
  localparam logic [WDAY_W-1:0] RST_WDAY  = 3'd2;

  // Reciprocal constants: y/100 = (y*CENT_RECIP)>>24 for any 16-bit y,
  // 26*(m+1)/10 = ((m+1)*ZELLER_K)>>16, v/7 = (v*WEEK_RECIP)>>18 for v < 2^14
  localparam int CENT_RECIP   = 167773;
  localparam int ZELLER_K     = 170404;
  localparam int WEEK_RECIP   = 37450;
  localparam int ZELLER_BIAS  = 7000;
  localparam int CENT_W       = 10;
  localparam int ZTERM_W      = 10;
  localparam int SUM_W        = 14;
  localparam int QUOT_W       = 11;

  // One input beat
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [YEAR_W-1:0] set_year;
    logic [BYTE_W-1:0] set_month;
    logic [BYTE_W-1:0] set_day;
    logic [BYTE_W-1:0] set_hour;
    logic [BYTE_W-1:0] set_minute;
    logic [BYTE_W-1:0] set_second;
    logic [CNT_W-1:0]  days_back;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [YEAR_W-1:0] cur_year;
    logic [BYTE_W-1:0] cur_month;
    logic [BYTE_W-1:0] cur_day;
    logic [BYTE_W-1:0] cur_hour;
    logic [BYTE_W-1:0] cur_minute;
    logic [BYTE_W-1:0] cur_second;
    logic [WDAY_W-1:0] weekday;
    logic              fields_valid;
    logic [BYTE_W-1:0] past_month;
    logic [BYTE_W-1:0] past_day;
  } result_t;

  // Source of the shared century divider
  typedef enum logic [1:0] {
    DIV_CUR,
    DIV_ADJ,
    DIV_PAST
  } div_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     take;
    logic     apply;
    div_sel_t div_sel;
    logic     wd_mul;
    logic     wd_sum;
    logic     wd_quot;
    logic     wd_fin;
    logic     load;
    logic     step;
    logic     emit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_wd;
    logic walk_done;
    logic out_free;
  } ctrl_status_t;

  // Days in month m; anything not February or a 30-day month has 31
  function automatic logic [BYTE_W-1:0] month_len(input logic [BYTE_W-1:0] m,
                                                  input logic leap);
    logic [BYTE_W-1:0] len;
    len = 8'd31;
    if (m == 8'd2) begin
      len = leap ? 8'd29 : 8'd28;
    end else if (m == 8'd4 || m == 8'd6 || m == 8'd9 || m == 8'd11) begin
      len = 8'd30;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ccw_if.sv =====
// Valid/ready channel interfaces for input and result beats.
`default_nettype none

interface ccw_item_if import ccw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [YEAR_W-1:0] set_year;
  logic [BYTE_W-1:0] set_month;
  logic [BYTE_W-1:0] set_day;
  logic [BYTE_W-1:0] set_hour;
  logic [BYTE_W-1:0] set_minute;
  logic [BYTE_W-1:0] set_second;
  logic [CNT_W-1:0]  days_back;

  modport source (
    output valid, cmd, set_year, set_month, set_day, set_hour, set_minute,
           set_second, days_back,
    input  ready
  );
  modport sink (
    input  valid, cmd, set_year, set_month, set_day, set_hour, set_minute,
           set_second, days_back,
    output ready
  );
endinterface

interface ccw_result_if import ccw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [YEAR_W-1:0] cur_year;
  logic [BYTE_W-1:0] cur_month;
  logic [BYTE_W-1:0] cur_day;
  logic [BYTE_W-1:0] cur_hour;
  logic [BYTE_W-1:0] cur_minute;
  logic [BYTE_W-1:0] cur_second;
  logic [WDAY_W-1:0] weekday;
  logic              fields_valid;
  logic [BYTE_W-1:0] past_month;
  logic [BYTE_W-1:0] past_day;

  modport source (
    output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
           weekday, fields_valid, past_month, past_day,
    input  ready
  );
  modport sink (
    input  valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
           weekday, fields_valid, past_month, past_day,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/calendar_clock_with_weekday_top.sv =====
// Top level of the calendar clock with weekday and past-date lookup.
//
//  channel  dir  payload                                      beat
//  item     in   cmd, set_year..set_second, days_back         one command
//  result   out  cur_year..cur_second, weekday, fields_valid,  one report
//                past_month, past_day
//
//  A beat passes capture, update, a weekday recompute when needed (set, or a
//  tick that ends a day), the past-date walk and the result hand-off in turn.
//  The past-date walker steps back one day a cycle until days_back days are done.
//  Reset restores 2019-01-01 08:00:00, Tuesday, and needs no clearing pass.
//  A finished report waits in the result register; the next beat is taken
//  meanwhile and only its own report waits for that register to free up.
`default_nettype none

module calendar_clock_with_weekday_top import ccw_pkg::*; (
  input logic          clk,
  input logic          rst,
  ccw_item_if.sink     item,
  ccw_result_if.source result
);

  ctrl_cmd_t    ctl;
  ctrl_status_t status;
  item_t        item_data;
  result_t      result_data;

  // Pack the input beat
  assign item_data.cmd        = item.cmd;
  assign item_data.set_year   = item.set_year;
  assign item_data.set_month  = item.set_month;
  assign item_data.set_day    = item.set_day;
  assign item_data.set_hour   = item.set_hour;
  assign item_data.set_minute = item.set_minute;
  assign item_data.set_second = item.set_second;
  assign item_data.days_back  = item.days_back;

  ccw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .ctl        (ctl),
    .status     (status)
  );

  ccw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .status       (status),
    .item         (item_data),
    .result       (result_data),
    .result_valid (result.valid),
    .result_ready (result.ready)
  );

  // Unpack the result beat
  assign result.cur_year     = result_data.cur_year;
  assign result.cur_month    = result_data.cur_month;
  assign result.cur_day      = result_data.cur_day;
  assign result.cur_hour     = result_data.cur_hour;
  assign result.cur_minute   = result_data.cur_minute;
  assign result.cur_second   = result_data.cur_second;
  assign result.weekday      = result_data.weekday;
  assign result.fields_valid = result_data.fields_valid;
  assign result.past_month   = result_data.past_month;
  assign result.past_day     = result_data.past_day;

endmodule

`default_nettype wire

// ===== rtl/ccw_dp.sv =====
// Datapath: time registers, weekday arithmetic, past-date walker, result register.
`default_nettype none

module ccw_dp import ccw_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ctrl_cmd_t    ctl,
  output ctrl_status_t status,
  input  item_t        item,
  output result_t      result,
  output logic         result_valid,
  input  logic         result_ready
);

  // Latched input beat
  item_t             item_q;
  logic              fv_q;

  // Time of day and calendar
  logic [YEAR_W-1:0] year_reg;
  logic [BYTE_W-1:0] month_reg;
  logic [BYTE_W-1:0] day_reg;
  logic [BYTE_W-1:0] hour_reg;
  logic [BYTE_W-1:0] minute_reg;
  logic [BYTE_W-1:0] second_reg;
  logic [WDAY_W-1:0] weekday_reg;

  // Century divider and leap flag
  logic [YEAR_W-1:0] div_src;
  logic [33:0]       div_prod;
  logic [YEAR_W-1:0] div_y;
  logic [CENT_W-1:0] div_c;
  logic [YEAR_W-1:0] hund;
  logic [YEAR_W-1:0] yy_full;
  logic [6:0]        yy;
  logic              leap_q;
  logic              leap_next;

  // Weekday pipeline
  logic              early_month;
  logic [YEAR_W-1:0] y_adj;
  logic [8:0]        m_plus;
  logic [26:0]       z_prod;
  logic [ZTERM_W-1:0] z_q;
  logic [SUM_W-1:0]  v_sum;
  logic [SUM_W-1:0]  v_q;
  logic [31:0]       q_prod;
  logic [QUOT_W-1:0] q_q;
  logic [SUM_W-1:0]  w_full;
  logic [WDAY_W-1:0] w;

  // Tick increments
  logic [BYTE_W-1:0] sec_inc, min_inc, hour_inc, day_inc, mon_inc;
  logic              sec_carry, min_carry, hour_carry, day_over, mon_over;

  // Past-date walker
  logic [YEAR_W-1:0] py;
  logic [BYTE_W-1:0] pm;
  logic [BYTE_W-1:0] pd;
  logic [CNT_W-1:0]  walk_cnt;
  logic [BYTE_W-1:0] pm_next;

  // Result register
  result_t           res_q;
  logic              out_full;

  // Divider source and century split
  always_comb begin
    case (ctl.div_sel)
      DIV_CUR:  div_src = year_reg;
      DIV_ADJ:  div_src = y_adj;
      DIV_PAST: div_src = py;
      default:  div_src = year_reg;
    endcase
  end

  assign div_prod  = 34'(div_src) * 34'(CENT_RECIP);
  assign hund      = 16'(div_c) * 16'd100;
  assign yy_full   = div_y - hund;
  assign yy        = yy_full[6:0];
  assign leap_next = (yy == 7'd0) ? (div_c[1:0] == 2'd0) : (div_y[1:0] == 2'd0);

  always_ff @(posedge clk) begin
    div_y  <= div_src;
    div_c  <= div_prod[33:24];
    leap_q <= leap_next;
  end

  // Tick carries, all from the registers before the update
  always_comb begin
    sec_inc    = second_reg + 8'd1;
    min_inc    = minute_reg + 8'd1;
    hour_inc   = hour_reg + 8'd1;
    day_inc    = day_reg + 8'd1;
    mon_inc    = month_reg + 8'd1;
    sec_carry  = sec_inc >= SEC_LIMIT;
    min_carry  = min_inc >= MIN_LIMIT;
    hour_carry = hour_inc >= HOUR_LIMIT;
    day_over   = day_inc > month_len(month_reg, leap_q);
    mon_over   = mon_inc > MONTHS;
  end

  // Weekday inputs: January and February belong to the previous year
  always_comb begin
    early_month = (month_reg == 8'd1) || (month_reg == 8'd2);
    y_adj       = early_month ? year_reg - 16'd1 : year_reg;
    m_plus      = early_month ? 9'(month_reg) + 9'd13 : 9'(month_reg) + 9'd1;
    z_prod      = 27'(m_plus) * 27'(ZELLER_K);
    v_sum       = SUM_W'(yy) + SUM_W'(yy >> 2) + SUM_W'(div_c >> 2) + SUM_W'(z_q)
                + SUM_W'(day_reg) + SUM_W'(ZELLER_BIAS)
                - SUM_W'({div_c, 1'b0}) - SUM_W'(1);
    q_prod      = 32'(v_q) * 32'(WEEK_RECIP);
    w_full      = v_q - SUM_W'(q_q) * SUM_W'(7);
    w           = w_full[WDAY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.wd_mul) begin
      z_q <= z_prod[25:16];
    end
    if (ctl.wd_sum) begin
      v_q <= v_sum;
    end
    if (ctl.wd_quot) begin
      q_q <= q_prod[28:18];
    end
  end

  // Capture the input beat and its range check
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      item_q <= item;
      fv_q   <= (item.set_year >= YEAR_MIN) && (item.set_year <= YEAR_MAX)
             && (item.set_month >= 8'd1) && (item.set_month <= MONTHS)
             && (item.set_day >= 8'd1) && (item.set_day <= DAY_MAX)
             && (item.set_hour < HOUR_LIMIT) && (item.set_minute < MIN_LIMIT)
             && (item.set_second < SEC_LIMIT);
    end
  end

  // Time registers: tick, set, weekday update
  always_ff @(posedge clk) begin
    if (rst) begin
      year_reg    <= RST_YEAR;
      month_reg   <= RST_MONTH;
      day_reg     <= RST_DAY;
      hour_reg    <= RST_HOUR;
      minute_reg  <= '0;
      second_reg  <= '0;
      weekday_reg <= RST_WDAY;
    end else begin
      if (ctl.apply) begin
        case (item_q.cmd)
          CMD_TICK: begin
            second_reg <= sec_carry ? '0 : sec_inc;
            if (sec_carry) begin
              minute_reg <= min_carry ? '0 : min_inc;
            end
            if (sec_carry && min_carry) begin
              hour_reg <= hour_carry ? '0 : hour_inc;
            end
            if (sec_carry && min_carry && hour_carry) begin
              day_reg <= day_over ? 8'd1 : day_inc;
              if (day_over) begin
                month_reg <= mon_over ? 8'd1 : mon_inc;
                if (mon_over) begin
                  year_reg <= year_reg + 16'd1;
                end
              end
            end
          end
          CMD_SET: begin
            year_reg   <= item_q.set_year;
            month_reg  <= item_q.set_month;
            day_reg    <= item_q.set_day;
            hour_reg   <= item_q.set_hour;
            minute_reg <= item_q.set_minute;
            second_reg <= item_q.set_second;
          end
          CMD_READ, CMD_SPARE: begin
            // hold
          end
          default: begin
            // hold
          end
        endcase
      end
      if (ctl.wd_fin) begin
        weekday_reg <= (w == '0) ? SUNDAY : w;
      end
    end
  end

  // Past-date walker: one day back per step
  assign pm_next = (pm > 8'd1) ? pm - 8'd1 : MONTHS;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      py       <= year_reg;
      pm       <= month_reg;
      pd       <= day_reg;
      walk_cnt <= item_q.days_back;
    end else if (ctl.step) begin
      walk_cnt <= walk_cnt - CNT_W'(1);
      if (pd > 8'd1) begin
        pd <= pd - 8'd1;
      end else begin
        pm <= pm_next;
        pd <= month_len(pm_next, leap_q);
        if (pm <= 8'd1) begin
          py <= py - 16'd1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (ctl.emit) begin
      out_full <= 1'b1;
    end else if (result_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      res_q.cur_year     <= year_reg;
      res_q.cur_month    <= month_reg;
      res_q.cur_day      <= day_reg;
      res_q.cur_hour     <= hour_reg;
      res_q.cur_minute   <= minute_reg;
      res_q.cur_second   <= second_reg;
      res_q.weekday      <= weekday_reg;
      res_q.fields_valid <= fv_q;
      res_q.past_month   <= pm;
      res_q.past_day     <= pd;
    end
  end

  assign result       = res_q;
  assign result_valid = out_full;

  // Status back to the controller
  assign status.need_wd   = (item_q.cmd == CMD_SET)
                          || ((item_q.cmd == CMD_TICK) && sec_carry && min_carry
                              && hour_carry);
  assign status.walk_done = (walk_cnt == '0);
  assign status.out_free  = !out_full || result_ready;

  // Checks
  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> walk_cnt != '0)
    else $error("walker stepped with no days left");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (!out_full || result_ready))
    else $error("result register overwritten before it was taken");

  a_weekday_code: assert property (@(posedge clk) disable iff (rst)
    ctl.wd_fin |=> weekday_reg != '0)
    else $error("weekday computed as zero");

endmodule

`default_nettype wire

// ===== rtl/ccw_ctrl.sv =====
// Controller: sequences capture, update, weekday, walk and result hand-off.
`default_nettype none

module ccw_ctrl import ccw_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  output ctrl_cmd_t    ctl,
  input  ctrl_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP0,
    S_PREP1,
    S_APPLY,
    S_WD0,
    S_WD1,
    S_WD2,
    S_WD3,
    S_LOAD,
    S_SETTLE,
    S_WALK,
    S_EMIT
  } state_t;

  state_t state;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:   if (item_valid) state <= S_PREP0;
        S_PREP0:  state <= S_PREP1;
        S_PREP1:  state <= S_APPLY;
        S_APPLY:  state <= status.need_wd ? S_WD0 : S_LOAD;
        S_WD0:    state <= S_WD1;
        S_WD1:    state <= S_WD2;
        S_WD2:    state <= S_WD3;
        S_WD3:    state <= S_LOAD;
        S_LOAD:   state <= S_SETTLE;
        S_SETTLE: state <= S_WALK;
        S_WALK:   if (status.walk_done) state <= S_EMIT;
        S_EMIT:   if (status.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // Command decode
  assign item_ready = (state == S_IDLE);

  always_comb begin
    ctl         = '0;
    ctl.div_sel = DIV_CUR;
    case (state)
      S_IDLE:   ctl.take = item_valid;
      S_APPLY:  ctl.apply = 1'b1;
      S_WD0: begin
        ctl.div_sel = DIV_ADJ;
        ctl.wd_mul  = 1'b1;
      end
      S_WD1:    ctl.wd_sum = 1'b1;
      S_WD2:    ctl.wd_quot = 1'b1;
      S_WD3:    ctl.wd_fin = 1'b1;
      S_LOAD:   ctl.load = 1'b1;
      S_SETTLE: ctl.div_sel = DIV_PAST;
      S_WALK: begin
        ctl.div_sel = DIV_PAST;
        ctl.step    = !status.walk_done;
      end
      S_EMIT:   ctl.emit = status.out_free;
      default: begin
        ctl.div_sel = DIV_CUR;
      end
    endcase
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && item_valid) |=> state == S_PREP0)
    else $error("accepted beat did not start processing");

  a_weekday_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && status.need_wd) |=> state == S_WD0)
    else $error("weekday recompute skipped");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && status.out_free) |=> (state == S_IDLE && $past(ctl.emit)))
    else $error("result not handed off on leaving emit");

endmodule

`default_nettype wire

// ===== tb/ccw_checker.sv =====
// Scoreboard for the calendar clock: predicts every report and checks the result channel.
`timescale 1ns / 1ps

module ccw_checker import ccw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ccw_item_if         item,
  ccw_result_if       result,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  // Keep the log readable when the block is badly broken
  localparam int unsigned REPORT_CAP = 100;

  // Shadow copy of the calendar registers
  logic [YEAR_W-1:0] cal_year;
  logic [BYTE_W-1:0] cal_month;
  logic [BYTE_W-1:0] cal_day;
  logic [BYTE_W-1:0] cal_hour;
  logic [BYTE_W-1:0] cal_minute;
  logic [BYTE_W-1:0] cal_second;
  logic [WDAY_W-1:0] cal_wday;

  result_t     due_reports[$];
  int unsigned shown = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Days in a month; any month code other than February or a 30-day month has 31
  function automatic logic [BYTE_W-1:0] days_in_month(input logic [YEAR_W-1:0] y,
                                                      input logic [BYTE_W-1:0] m);
    logic leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m == 8'd2) return leap ? 8'd29 : 8'd28;
    if (m == 8'd4 || m == 8'd6 || m == 8'd9 || m == 8'd11) return 8'd30;
    return 8'd31;
  endfunction

  // Zeller with the full century, 1 Monday .. 7 Sunday
  function automatic logic [WDAY_W-1:0] day_of_week(input logic [YEAR_W-1:0] y,
                                                    input logic [BYTE_W-1:0] m,
                                                    input logic [BYTE_W-1:0] d);
    int unsigned yr, mo, yy, cent, w;
    yr = 32'(y);
    mo = 32'(m);
    // January and February count as months 13 and 14 of the year before
    if (mo == 1 || mo == 2) begin
      yr = (yr - 1) & 32'hFFFF;
      mo = mo + 12;
    end
    yy   = yr % 100;
    cent = yr / 100;
    w    = (yy + yy / 4 + cent / 4 + (26 * (mo + 1)) / 10 + 32'(d) + 7000 - 2 * cent - 1)
           % 7;
    return (w == 0) ? SUNDAY : w[WDAY_W-1:0];
  endfunction

  // Apply one command to the shadow calendar and work out its report
  task automatic advance_calendar(input item_t it, output result_t rep);
    logic [YEAR_W-1:0] py;
    logic [BYTE_W-1:0] pm, pd;
    logic              in_range;
    in_range = it.set_year >= YEAR_MIN && it.set_year <= YEAR_MAX &&
               it.set_month >= 8'd1 && it.set_month <= MONTHS &&
               it.set_day >= 8'd1 && it.set_day <= DAY_MAX &&
               it.set_hour < HOUR_LIMIT && it.set_minute < MIN_LIMIT &&
               it.set_second < SEC_LIMIT;
    case (it.cmd)
      CMD_TICK: begin
        // Carry through second, minute and hour in 8 bits, then day, month, year
        cal_second = cal_second + 8'd1;
        if (cal_second >= SEC_LIMIT) begin
          cal_second = '0;
          cal_minute = cal_minute + 8'd1;
          if (cal_minute >= MIN_LIMIT) begin
            cal_minute = '0;
            cal_hour   = cal_hour + 8'd1;
            if (cal_hour >= HOUR_LIMIT) begin
              cal_hour = '0;
              cal_day  = cal_day + 8'd1;
              if (cal_day > days_in_month(cal_year, cal_month)) begin
                cal_day   = 8'd1;
                cal_month = cal_month + 8'd1;
                if (cal_month > MONTHS) begin
                  cal_month = 8'd1;
                  cal_year  = cal_year + 16'd1;
                end
              end
              cal_wday = day_of_week(cal_year, cal_month, cal_day);
            end
          end
        end
      end
      CMD_SET: begin
        // Load everything unchecked
        cal_year   = it.set_year;
        cal_month  = it.set_month;
        cal_day    = it.set_day;
        cal_hour   = it.set_hour;
        cal_minute = it.set_minute;
        cal_second = it.set_second;
        cal_wday   = day_of_week(cal_year, cal_month, cal_day);
      end
      default: begin
        // Read and the spare code leave the calendar alone
      end
    endcase

    // Walk back one day at a time from the current date
    py = cal_year;
    pm = cal_month;
    pd = cal_day;
    for (int unsigned i = 0; i < 32'(it.days_back); i++) begin
      if (pd > 8'd1) begin
        pd = pd - 8'd1;
      end else begin
        if (pm > 8'd1) begin
          pm = pm - 8'd1;
        end else begin
          pm = MONTHS;
          py = py - 16'd1;
        end
        pd = days_in_month(py, pm);
      end
    end

    rep.cur_year     = cal_year;
    rep.cur_month    = cal_month;
    rep.cur_day      = cal_day;
    rep.cur_hour     = cal_hour;
    rep.cur_minute   = cal_minute;
    rep.cur_second   = cal_second;
    rep.weekday      = cal_wday;
    rep.fields_valid = in_range;
    rep.past_month   = pm;
    rep.past_day     = pd;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (shown < REPORT_CAP) begin
        shown++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  // Predict on every accepted command, compare on every accepted report
  always @(posedge clk) begin
    item_t   beat;
    result_t want, got;
    if (rst) begin
      cal_year   = RST_YEAR;
      cal_month  = RST_MONTH;
      cal_day    = RST_DAY;
      cal_hour   = RST_HOUR;
      cal_minute = '0;
      cal_second = '0;
      cal_wday   = RST_WDAY;
      due_reports.delete();
    end else begin
      if (item.valid && item.ready) begin
        beat.cmd        = item.cmd;
        beat.set_year   = item.set_year;
        beat.set_month  = item.set_month;
        beat.set_day    = item.set_day;
        beat.set_hour   = item.set_hour;
        beat.set_minute = item.set_minute;
        beat.set_second = item.set_second;
        beat.days_back  = item.days_back;
        advance_calendar(beat, want);
        due_reports.push_back(want);
      end
      if (result.valid && result.ready) begin
        got.cur_year     = result.cur_year;
        got.cur_month    = result.cur_month;
        got.cur_day      = result.cur_day;
        got.cur_hour     = result.cur_hour;
        got.cur_minute   = result.cur_minute;
        got.cur_second   = result.cur_second;
        got.weekday      = result.weekday;
        got.fields_valid = result.fields_valid;
        got.past_month   = result.past_month;
        got.past_day     = result.past_day;
        if (due_reports.size() == 0) begin
          fail_count++;
          if (shown < REPORT_CAP) begin
            shown++;
            $display("%0t: report with none expected: expected nothing, actual %p",
                     $time, got);
          end
        end else begin
          want = due_reports.pop_front();
          check_field("cur_year", 32'(want.cur_year), 32'(got.cur_year));
          check_field("cur_month", 32'(want.cur_month), 32'(got.cur_month));
          check_field("cur_day", 32'(want.cur_day), 32'(got.cur_day));
          check_field("cur_hour", 32'(want.cur_hour), 32'(got.cur_hour));
          check_field("cur_minute", 32'(want.cur_minute), 32'(got.cur_minute));
          check_field("cur_second", 32'(want.cur_second), 32'(got.cur_second));
          check_field("weekday", 32'(want.weekday), 32'(got.weekday));
          check_field("fields_valid", 32'(want.fields_valid), 32'(got.fields_valid));
          check_field("past_month", 32'(want.past_month), 32'(got.past_month));
          check_field("past_day", 32'(want.past_day), 32'(got.past_day));
        end
      end
    end
    outstanding <= due_reports.size();
  end

endmodule

// ===== tb/tb_calendar_clock_with_weekday_top.sv =====
// Testbench top: drives commands into the calendar clock and gives the verdict.
`timescale 1ns / 1ps

module tb_calendar_clock_with_weekday_top import ccw_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_BEATS = 78;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LONG_HOLD    = 400;

  logic        clk;
  logic        rst;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned burst_left = 0;

  ccw_item_if   item_ch ();
  ccw_result_if result_ch ();

  calendar_clock_with_weekday_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  ccw_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Give up on a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** calendar_clock_with_weekday_top: FAILED **");
      $finish;
    end
  end

  function automatic item_t beat_of(input logic [CMD_W-1:0] c, input logic [YEAR_W-1:0] y,
                                    input logic [BYTE_W-1:0] mo, input logic [BYTE_W-1:0] d,
                                    input logic [BYTE_W-1:0] h, input logic [BYTE_W-1:0] mi,
                                    input logic [BYTE_W-1:0] s, input logic [CNT_W-1:0] back);
    item_t b;
    b.cmd        = c;
    b.set_year   = y;
    b.set_month  = mo;
    b.set_day    = d;
    b.set_hour   = h;
    b.set_minute = mi;
    b.set_second = s;
    b.days_back  = back;
    return b;
  endfunction

  // Offer one beat, in bursts with random gaps, and hold it until taken
  task automatic send_beat(input item_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        item_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    item_ch.valid      <= 1'b1;
    item_ch.cmd        <= b.cmd;
    item_ch.set_year   <= b.set_year;
    item_ch.set_month  <= b.set_month;
    item_ch.set_day    <= b.set_day;
    item_ch.set_hour   <= b.set_hour;
    item_ch.set_minute <= b.set_minute;
    item_ch.set_second <= b.set_second;
    item_ch.days_back  <= b.days_back;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  // Result side: stall on a changing pattern, with two long hold-offs
  initial begin
    int unsigned mode, span, spent, long_holds;
    result_ch.ready = 1'b0;
    spent      = 0;
    long_holds = 0;
    wait (!rst);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(negedge clk);
        spent++;
        case (mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= ($urandom_range(0, 1) == 0);
          2:       result_ch.ready <= ($urandom_range(0, 3) != 0);
          default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      // Hold off long enough for the block to fill up and stall its input
      if ((long_holds == 0 && spent >= 300) || (long_holds == 1 && spent >= 4000)) begin
        long_holds++;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          spent++;
          result_ch.ready <= 1'b0;
        end
      end
    end
  end

  // Command side: directed corners, then random traffic, then the verdict
  initial begin
    item_t       b;
    int unsigned pick;
    rst                = 1'b1;
    item_ch.valid      = 1'b0;
    item_ch.cmd        = CMD_READ;
    item_ch.set_year   = '0;
    item_ch.set_month  = '0;
    item_ch.set_day    = '0;
    item_ch.set_hour   = '0;
    item_ch.set_minute = '0;
    item_ch.set_second = '0;
    item_ch.days_back  = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset state, then the range check bounds carried on ticks
    send_beat(beat_of(CMD_READ, 2019, 1, 1, 8, 0, 0, 0));
    send_beat(beat_of(CMD_TICK, 2014, 1, 1, 0, 0, 0, 1));
    // Year rollover
    send_beat(beat_of(CMD_SET, 2019, 12, 31, 23, 59, 59, 0));
    send_beat(beat_of(CMD_TICK, 2015, 1, 1, 0, 0, 0, 366));
    // Leap February, plain century, leap century
    send_beat(beat_of(CMD_SET, 2020, 2, 28, 23, 59, 59, 60));
    send_beat(beat_of(CMD_TICK, 2050, 12, 31, 23, 59, 59, 29));
    send_beat(beat_of(CMD_SET, 2020, 2, 29, 23, 59, 59, 0));
    send_beat(beat_of(CMD_TICK, 2051, 12, 31, 23, 59, 59, 1));
    send_beat(beat_of(CMD_SET, 2100, 2, 28, 23, 59, 59, 0));
    send_beat(beat_of(CMD_TICK, 2015, 13, 1, 0, 0, 0, 1));
    send_beat(beat_of(CMD_SET, 2000, 2, 28, 23, 59, 59, 400));
    send_beat(beat_of(CMD_TICK, 2015, 1, 32, 0, 0, 0, 1));
    // Year wraps to zero, and the walk wraps back to the top year
    send_beat(beat_of(CMD_SET, 16'hFFFF, 12, 31, 23, 59, 59, 0));
    send_beat(beat_of(CMD_TICK, 2015, 1, 1, 24, 0, 0, 0));
    send_beat(beat_of(CMD_READ, 2015, 1, 1, 0, 0, 0, 400));
    // Month beyond twelve rolls into the next year
    send_beat(beat_of(CMD_SET, 2030, 13, 31, 23, 59, 59, 45));
    send_beat(beat_of(CMD_TICK, 2015, 1, 1, 0, 60, 0, 3));
    // Out-of-range loads: month and day zero, counters at 255
    send_beat(beat_of(CMD_SET, 2040, 0, 0, 255, 255, 255, 40));
    send_beat(beat_of(CMD_TICK, 2015, 1, 1, 0, 0, 60, 2));
    send_beat(beat_of(CMD_SET, 2024, 4, 255, 23, 59, 59, 3));
    send_beat(beat_of(CMD_TICK, 2015, 1, 0, 0, 0, 0, 5));
    // Spare code with everything at its top value, including the longest walk
    send_beat(beat_of(CMD_SPARE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));

    // Random traffic: near-rollover sets followed by ticks, reads and noise
    for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 1) == 0) begin
        b = beat_of(CMD_TICK, YEAR_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                    BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), '0);
      end else begin
        b = beat_of(CMD_TICK, YEAR_W'($urandom_range(2010, 2055)),
                    BYTE_W'($urandom_range(0, 13)), BYTE_W'($urandom_range(0, 32)),
                    BYTE_W'($urandom_range(0, 24)), BYTE_W'($urandom_range(0, 60)),
                    BYTE_W'($urandom_range(0, 60)), '0);
      end
      if (pick < 22) begin
        b.cmd = CMD_SET;
        if ($urandom_range(0, 3) != 0) begin
          // Close to midnight, often near a month end, so that following ticks roll over
          case ($urandom_range(0, 7))
            0:       b.set_year = 2000;
            1:       b.set_year = 2100;
            2:       b.set_year = 1900;
            3:       b.set_year = 16'hFFFF;
            default: b.set_year = YEAR_W'($urandom_range(2015, 2050));
          endcase
          b.set_month  = BYTE_W'($urandom_range(1, 12));
          b.set_day    = ($urandom_range(0, 1) == 0) ? BYTE_W'($urandom_range(28, 31))
                                                     : BYTE_W'($urandom_range(1, 31));
          b.set_hour   = 23;
          b.set_minute = 59;
          b.set_second = BYTE_W'($urandom_range(50, 59));
        end
      end else if (pick < 80) begin
        b.cmd = CMD_TICK;
      end else begin
        b.cmd = ($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_READ;
      end
      if (n % 33 == 32) begin
        b.days_back = 16'hFFFF;
      end else if ($urandom_range(0, 5) == 0) begin
        b.days_back = CNT_W'($urandom_range(0, 800));
      end else begin
        b.days_back = CNT_W'($urandom_range(0, 60));
      end
      send_beat(b);
    end

    @(negedge clk);
    item_ch.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** calendar_clock_with_weekday_top: PASSED **");
    end else begin
      $display("** calendar_clock_with_weekday_top: FAILED **");
    end
    $finish;
  end

endmodule
